// ----- design/ewh_pkg.sv -----
// Shared types and constants for the equal-width histogram block.
`timescale 1ns / 1ps

package ewh_pkg;

   // Fixed field widths of the channels.
   localparam int SAMPLE_W = 16;
   localparam int OUT_W    = 16;
   localparam int BIN_IDX_W = 6;
   localparam int USED_W   = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BINS_USED = 2'd2;

   // Configuration reset values.
   localparam logic [SAMPLE_W-1:0] RANGE_LOW_RST = 16'h8000;
   localparam logic [SAMPLE_W-1:0] BIN_WIDTH_RST = 16'd4096;
   localparam logic [USED_W-1:0]   BINS_USED_RST = 7'd16;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DIV    = 7'b0000010,
      ST_RD     = 7'b0000100,
      ST_WR     = 7'b0001000,
      ST_EM_RD  = 7'b0010000,
      ST_EM_LD  = 7'b0100000,
      ST_EM_OUT = 7'b1000000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture a request and set up the bin search
      logic step;       // one restoring division step
      logic rd_bin;     // read the count of the selected bin
      logic wr_bin;     // write back the incremented count
      logic emit_rd;    // read the count of the bin being reported
      logic emit_load;  // fill the response register
      logic emit_next;  // advance to the next bin to report
      logic clear;      // drop all counts and the set size
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic set_last;
      logic emit_final;
      logic rsp_taken;
   } status_type;

endpackage

// ----- design/ewh_intf.sv -----
// Channel interfaces: sample requests, bin responses and register writes.
`timescale 1ns / 1ps

interface ewh_req_if import ewh_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

interface ewh_rsp_if import ewh_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BIN_IDX_W-1:0] bin_index;
   logic [OUT_W-1:0]     bin_total;
   logic [OUT_W-1:0]     set_size;
   logic                 final_bin;

   modport source (output valid, output bin_index, output bin_total, output set_size,
                   output final_bin, input ready);
   modport sink   (input valid, input bin_index, input bin_total, input set_size,
                   input final_bin, output ready);
endinterface

interface ewh_csr_if import ewh_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/ewh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ewh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/ewh_ctrl.sv -----
// Sequencer for binning one sample and for reporting the bins of a set.
`timescale 1ns / 1ps

module ewh_ctrl import ewh_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (status.div_done) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.rd_bin = 1'b1;
            state_in   = ST_WR;
         end
         ST_WR: begin
            cmd.wr_bin = 1'b1;
            state_in   = status.set_last ? ST_EM_RD : ST_IDLE;
         end
         ST_EM_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = ST_EM_LD;
         end
         ST_EM_LD: begin
            cmd.emit_load = 1'b1;
            state_in      = ST_EM_OUT;
         end
         ST_EM_OUT: begin
            if (status.rsp_taken) begin
               if (status.emit_final) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = ST_EM_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/ewh_dp.sv -----
// Datapath: registers, bin search by restoring division, count memory, response register.
`timescale 1ns / 1ps

module ewh_dp import ewh_pkg::*; #(
   parameter int MAX_BINS   = 64,
   parameter int COUNT_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data,
   input  logic signed [SAMPLE_W-1:0]  req_sample,
   input  logic                        req_last,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [BIN_IDX_W-1:0]        rsp_bin_index,
   output logic [OUT_W-1:0]            rsp_bin_total,
   output logic [OUT_W-1:0]            rsp_set_size,
   output logic                        rsp_final_bin
);

   localparam int IDX_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int STEP_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;
   localparam int DW     = SAMPLE_W + IDX_W;

   function automatic logic [OUT_W-1:0] sat_out(input logic [COUNT_BITS-1:0] c);
      return (32'(c) > 32'hFFFF) ? 16'hFFFF : OUT_W'(c);
   endfunction

   // Configuration registers.
   logic signed [SAMPLE_W-1:0] range_low_ff;
   logic [SAMPLE_W-1:0]        bin_width_ff;
   logic [USED_W-1:0]          bins_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff <= RANGE_LOW_RST;
         bin_width_ff <= BIN_WIDTH_RST;
         bins_used_ff <= BINS_USED_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RANGE_LOW: range_low_ff <= csr_data;
            CSR_BIN_WIDTH: bin_width_ff <= csr_data;
            CSR_BINS_USED: bins_used_ff <= csr_data[USED_W-1:0];
            default: ;
         endcase
      end
   end

   logic [USED_W-1:0] used;
   logic [IDX_W-1:0]  last_bin;

   always_comb begin
      if (bins_used_ff == '0) begin
         used = USED_W'(1);
      end else if (bins_used_ff > USED_W'(MAX_BINS)) begin
         used = USED_W'(MAX_BINS);
      end else begin
         used = bins_used_ff;
      end
      last_bin = IDX_W'(used - USED_W'(1));
   end

   // Bin search: quotient of (sample - range_low) by the width, one bit per step.
   logic [SAMPLE_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0]    quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                oor_ff, oor_in;
   logic                last_ff;
   logic [SAMPLE_W:0]   diff;
   logic [DW-1:0]       divisor;

   assign diff    = {req_sample[SAMPLE_W-1], req_sample}
                  - {range_low_ff[SAMPLE_W-1], range_low_ff};
   assign divisor = DW'(bin_width_ff) << step_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      oor_in  = oor_ff;
      if (cmd.load) begin
         rem_in  = diff[SAMPLE_W-1:0];
         quo_in  = '0;
         step_in = STEP_W'(IDX_W - 1);
         // Below the range, or a quotient too large for any bin (zero width included).
         oor_in  = diff[SAMPLE_W]
                 | (DW'(diff[SAMPLE_W-1:0]) >= (DW'(bin_width_ff) << IDX_W));
      end else if (cmd.step) begin
         if (DW'(rem_ff) >= divisor) begin
            rem_in = rem_ff - divisor[SAMPLE_W-1:0];
            quo_in = quo_ff | (IDX_W'(1) << step_ff);
         end
         if (step_ff != '0) begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      oor_ff  <= oor_in;
      if (cmd.load) begin
         last_ff <= req_last;
      end
   end

   logic [IDX_W-1:0] bin_sel;
   logic [IDX_W-1:0] bin_ff;

   assign bin_sel = (!oor_ff && (USED_W'(quo_ff) < used)) ? quo_ff : last_bin;

   always_ff @(posedge clock) begin
      if (cmd.rd_bin) begin
         bin_ff <= bin_sel;
      end
   end

   // Count memory with one valid bit per bin; an invalid bin reads as zero.
   logic [MAX_BINS-1:0]   valid_ff;
   logic [COUNT_BITS-1:0] ram_rdata;
   logic [COUNT_BITS-1:0] base_cnt;
   logic [COUNT_BITS-1:0] next_cnt;
   logic [COUNT_BITS-1:0] seen_ff;
   logic [IDX_W-1:0]      k_ff;

   assign base_cnt = valid_ff[bin_ff] ? ram_rdata : '0;
   assign next_cnt = (base_cnt == '1) ? base_cnt : base_cnt + COUNT_BITS'(1);

   ewh_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (MAX_BINS)
   ) u_count_ram (
      .clock (clock),
      .we    (cmd.wr_bin),
      .waddr (bin_ff),
      .wdata (next_cnt),
      .re    (cmd.rd_bin | cmd.emit_rd),
      .raddr (cmd.emit_rd ? k_ff : bin_sel),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff <= '0;
         seen_ff  <= '0;
         k_ff     <= '0;
      end else begin
         if (cmd.wr_bin) begin
            valid_ff[bin_ff] <= 1'b1;
            if (seen_ff != '1) begin
               seen_ff <= seen_ff + COUNT_BITS'(1);
            end
         end
         if (cmd.emit_next) begin
            k_ff <= k_ff + IDX_W'(1);
         end
      end
   end

   // Response register.
   logic                 rsp_valid_ff;
   logic [BIN_IDX_W-1:0] bin_index_ff;
   logic [OUT_W-1:0]     bin_total_ff;
   logic [OUT_W-1:0]     set_size_ff;
   logic                 final_bin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         bin_index_ff <= BIN_IDX_W'(k_ff);
         bin_total_ff <= valid_ff[k_ff] ? sat_out(ram_rdata) : '0;
         set_size_ff  <= sat_out(seen_ff);
         final_bin_ff <= (k_ff == last_bin);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_index = bin_index_ff;
   assign rsp_bin_total = bin_total_ff;
   assign rsp_set_size  = set_size_ff;
   assign rsp_final_bin = final_bin_ff;

   assign status.div_done   = (step_ff == '0);
   assign status.set_last   = last_ff;
   assign status.emit_final = (k_ff == last_bin);
   assign status.rsp_taken  = rsp_valid_ff & rsp_ready;

endmodule

// ----- design/equal_width_histogram.sv -----
// Top level of the equal-width histogram: channels, controller, datapath, checks.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// req_ch    in         valid / ready      sample (Q1.15), last
// rsp_ch    out        valid / ready      bin_index, bin_total, set_size, final_bin
// csr_ch    in         valid / ready (=1) index, data
//
// Each request is accepted, then runs one restoring division step per bin index bit,
// then a read and a write of the count memory. A request flagged last is followed
// by a report of every bin in use, each bin going through ST_EM_RD, ST_EM_LD and
// ST_EM_OUT; a stalled response holds the block in place.
// Reset loads the register defaults and empties every bin at once through a valid
// bit per bin, so no clearing pass is needed.

module equal_width_histogram import ewh_pkg::*; #(
   parameter int MAX_BINS   = 64,
   parameter int COUNT_BITS = 16
) (
   input logic             clock,
   input logic             reset,
   ewh_req_if.sink         req_ch,
   ewh_rsp_if.source       rsp_ch,
   ewh_csr_if.sink         csr_ch
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   // Register writes are always taken; the user must write the block only while idle, which the block does not enforce.
   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = req_ready;

   // The controller walks each request through search, update and, at the end
   // of a set, the per-bin report.
   ewh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath owns the registers, the division unit, the count memory and
   // the response register.
   ewh_dp #(
      .MAX_BINS   (MAX_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_we        (csr_ch.valid),
      .csr_index     (csr_ch.index),
      .csr_data      (csr_ch.data),
      .req_sample    (req_ch.sample),
      .req_last      (req_ch.last),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_bin_index (rsp_ch.bin_index),
      .rsp_bin_total (rsp_ch.bin_total),
      .rsp_set_size  (rsp_ch.set_size),
      .rsp_final_bin (rsp_ch.final_bin)
   );

   // A new request is never taken while a response is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request accepted while a response is pending");

   // The response for the last bin returns the block to accepting requests.
   a_final_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.final_bin) |=> req_ch.ready)
      else $error("block not idle after the final bin was reported");

   // Any other response keeps the report going.
   a_report_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.final_bin) |=> !req_ch.ready)
      else $error("report ended before the final bin");

   // A reported set always holds at least the sample that ended it.
   a_set_nonempty: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> (rsp_ch.set_size != 16'd0))
      else $error("report of an empty set");

endmodule
